### hw/rtl/bb3_pkg.sv
// Shared types, constants and the reciprocal table of the 3x3 box blur.
package bb3_pkg;

  localparam int unsigned MAX_WIDTH_DEFAULT  = 1024;
  localparam int unsigned MAX_HEIGHT_DEFAULT = 4096;

  localparam int unsigned CFG_WIDTH_BITS  = 11;
  localparam int unsigned CFG_HEIGHT_BITS = 13;
  localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;

  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

  localparam int unsigned CHAN_BITS   = 8;
  localparam int unsigned SUM_BITS    = 12;
  localparam int unsigned COUNT_BITS  = 4;
  localparam int unsigned RECIP_BITS  = 17;
  localparam int unsigned RECIP_SHIFT = 16;

  typedef logic [CHAN_BITS-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pix_t;

  typedef struct packed {
    logic  operation;
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
  } in_item_t;

  typedef struct packed {
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;
    logic  frame_last;
  } out_item_t;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_RMW,
    ST_SUM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic has_up;
    logic has_down;
    logic has_left;
    logic has_right;
  } clip_t;

  // window[row][col], row 0 is the upper row, col 0 the left column
  typedef pix_t [2:0][2:0] win_t;

  // ceil(2^RECIP_SHIFT / n) for the neighbor counts that can occur
  function automatic logic [RECIP_BITS-1:0] recip(input logic [COUNT_BITS-1:0] n);
    logic [RECIP_BITS-1:0] k;
    case (n)
      4'd1:    k = 17'd65536;
      4'd2:    k = 17'd32768;
      4'd3:    k = 17'd21846;
      4'd4:    k = 17'd16384;
      4'd6:    k = 17'd10923;
      4'd9:    k = 17'd7282;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

### hw/rtl/bb3_stream_if.sv
// Valid/ready request channels for blur input items and result items.
interface bb3_in_if;
  logic               valid;
  logic               ready;
  bb3_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bb3_out_if;
  logic               valid;
  logic               ready;
  bb3_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/bb3_line_buf.sv
// Two line stores holding the two rows above the incoming row, with row shift on write.
module bb3_line_buf #(
  parameter int unsigned DEPTH = bb3_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  bb3_pkg::pix_t            pix_i,
  output bb3_pkg::pix_t            upper_o,
  output bb3_pkg::pix_t            middle_o
);

  bb3_pkg::pix_t upper_mem  [DEPTH];
  bb3_pkg::pix_t middle_mem [DEPTH];
  bb3_pkg::pix_t upper_q;
  bb3_pkg::pix_t middle_q;

  // move the middle row entry up, store the new pixel as middle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[addr_i]  <= middle_q;
      middle_mem[addr_i] <= pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      upper_q  <= upper_mem[addr_i];
      middle_q <= middle_mem[addr_i];
    end
  end

  assign upper_o  = upper_q;
  assign middle_o = middle_q;

endmodule

### hw/rtl/bb3_avg.sv
// Clipped 3x3 sum with half-up rounding and division by reciprocal multiply.
module bb3_avg (
  input  logic           clk_i,
  input  logic           load_i,
  input  bb3_pkg::win_t  win_i,
  input  bb3_pkg::clip_t clip_i,
  output bb3_pkg::pix_t  avg_o
);

  localparam int unsigned SUM_W  = bb3_pkg::SUM_BITS;
  localparam int unsigned CNT_W  = bb3_pkg::COUNT_BITS;
  localparam int unsigned RCP_W  = bb3_pkg::RECIP_BITS;
  localparam int unsigned PROD_W = SUM_W + RCP_W;

  logic [2:0]       row_ok;
  logic [2:0]       col_ok;
  logic [1:0]       rows;
  logic [1:0]       cols;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum [3];
  logic [SUM_W-1:0] m_d [3];
  logic [SUM_W-1:0] m_q [3];
  logic [RCP_W-1:0] k_q;
  logic [PROD_W-1:0] prod [3];

  always_comb begin
    row_ok = {clip_i.has_down, 1'b1, clip_i.has_up};
    col_ok = {clip_i.has_right, 1'b1, clip_i.has_left};
    rows   = 2'd1 + 2'(clip_i.has_up) + 2'(clip_i.has_down);
    cols   = 2'd1 + 2'(clip_i.has_left) + 2'(clip_i.has_right);
    count  = CNT_W'(rows) * CNT_W'(cols);
    for (int c = 0; c < 3; c++) begin
      sum[c] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_ok[i] && col_ok[j]) begin
          sum[0] = sum[0] + SUM_W'(win_i[i][j].red);
          sum[1] = sum[1] + SUM_W'(win_i[i][j].green);
          sum[2] = sum[2] + SUM_W'(win_i[i][j].blue);
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      m_d[c] = sum[c] + SUM_W'(count >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      m_q <= m_d;
      k_q <= bb3_pkg::recip(count);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = PROD_W'(m_q[c]) * PROD_W'(k_q);
    end
    avg_o.red   = prod[0][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_BITS];
    avg_o.green = prod[1][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_BITS];
    avg_o.blue  = prod[2][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_BITS];
  end

endmodule

### hw/rtl/box_blur_3x3_edge_clipped.sv
// Top level of the streaming 3x3 box blur with edges clipped to the frame.
//
//   channel   role     handshake             carries
//   in_i      sink     valid/ready           operation, red_in, green_in, blue_in
//   out_o     source   valid/ready           red_out, green_out, blue_out, frame_last
//   apb       slave    psel/penable, ready=1 frame_width @0x0, frame_height @0x4
//
// A request without result passes through line store read, then write-back and
// window shift; one with a result adds sum and divide and waits while the output
// register is full. The first drain of a one-row frame adds an ISSUE and an RMW.
// The line stores share one address; a new request is taken only back in ST_IDLE.
// Reset clears positions and loads 640x480; line store contents are not cleared.
module box_blur_3x3_edge_clipped #(
  parameter int unsigned MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bb3_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [bb3_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [bb3_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  bb3_in_if.sink                             in_i,
  bb3_out_if.source                          out_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned CFG_W = bb3_pkg::CFG_WIDTH_BITS;
  localparam int unsigned CFG_H = bb3_pkg::CFG_HEIGHT_BITS;
  localparam int unsigned DAT_W = bb3_pkg::APB_DATA_BITS;

  bb3_pkg::state_e state_q, state_d;

  logic [CFG_W-1:0] cfg_w_q;
  logic [CFG_H-1:0] cfg_h_q;
  logic [WID_W-1:0] eff_w;
  logic [HGT_W-1:0] eff_h;

  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] push_row_q;
  logic [COL_W-1:0] push_col_q;
  bb3_pkg::pix_t    pix_q;
  logic             virt_q;
  bb3_pkg::clip_t   clip_q;
  logic             last_q;
  bb3_pkg::win_t    win_q;

  logic             out_valid_q;
  bb3_pkg::pix_t    out_pix_q;
  logic             out_last_q;

  bb3_pkg::reg_e    reg_idx;
  logic             cfg_wr;
  logic             accept;
  logic             frame_done;
  logic             start_push;
  logic             out_free;

  logic             emit;
  logic [ROW_W-1:0] out_r;
  logic [COL_W-1:0] out_c;
  bb3_pkg::clip_t   clip_d;
  logic             last_d;
  logic [WID_W-1:0] col_inc;
  logic             wrap;

  logic             mem_rd;
  logic             mem_wr;
  logic [COL_W-1:0] mem_addr;
  logic             avg_load;
  logic             out_load;
  bb3_pkg::pix_t    lb_upper;
  bb3_pkg::pix_t    lb_middle;
  bb3_pkg::pix_t    avg_pix;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = bb3_pkg::reg_e'(paddr[bb3_pkg::APB_ADDR_BITS-1]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      bb3_pkg::REG_WIDTH:  prdata = DAT_W'(cfg_w_q);
      bb3_pkg::REG_HEIGHT: prdata = DAT_W'(cfg_h_q);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= bb3_pkg::WIDTH_RESET;
      cfg_h_q <= bb3_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bb3_pkg::REG_WIDTH:  cfg_w_q <= pwdata[CFG_W-1:0];
        bb3_pkg::REG_HEIGHT: cfg_h_q <= pwdata[CFG_H-1:0];
        default: ;
      endcase
    end
  end

  // clamp frame size to 1..MAX
  always_comb begin
    if (cfg_w_q == '0) begin
      eff_w = WID_W'(1);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      eff_h = HGT_W'(1);
    end else if (32'(cfg_h_q) > MAX_HEIGHT) begin
      eff_h = HGT_W'(MAX_HEIGHT);
    end else begin
      eff_h = HGT_W'(cfg_h_q);
    end
  end

  // request decode
  assign in_i.ready = (state_q == bb3_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign frame_done = row_q >= ROW_W'(eff_h);
  assign start_push = accept && (frame_done || in_i.data.operation == bb3_pkg::OP_PUSH);
  assign out_free   = !out_valid_q || out_o.ready;

  // position of the output that the current push completes
  always_comb begin
    emit    = (push_row_q >= ROW_W'(2)) || (push_row_q == ROW_W'(1) && push_col_q != '0);
    col_inc = WID_W'(push_col_q) + WID_W'(1);
    wrap    = col_inc >= eff_w;
    if (push_col_q != '0) begin
      out_r = push_row_q - ROW_W'(1);
      out_c = push_col_q - COL_W'(1);
    end else begin
      out_r = push_row_q - ROW_W'(2);
      out_c = COL_W'(eff_w - WID_W'(1));
    end
    clip_d.has_up    = out_r != '0;
    clip_d.has_down  = out_r != (ROW_W'(eff_h) - ROW_W'(1));
    clip_d.has_left  = out_c != '0;
    clip_d.has_right = WID_W'(out_c) != (eff_w - WID_W'(1));
    last_d           = !clip_d.has_down && !clip_d.has_right;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bb3_pkg::ST_IDLE: begin
        if (start_push) state_d = bb3_pkg::ST_RMW;
      end
      bb3_pkg::ST_ISSUE: state_d = bb3_pkg::ST_RMW;
      bb3_pkg::ST_RMW: begin
        if (emit) begin
          state_d = bb3_pkg::ST_SUM;
        end else if (virt_q) begin
          state_d = bb3_pkg::ST_ISSUE;
        end else begin
          state_d = bb3_pkg::ST_IDLE;
        end
      end
      bb3_pkg::ST_SUM: state_d = bb3_pkg::ST_OUT;
      bb3_pkg::ST_OUT: begin
        if (out_free) state_d = bb3_pkg::ST_IDLE;
      end
      default: state_d = bb3_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    mem_rd   = 1'b0;
    mem_wr   = 1'b0;
    mem_addr = col_q;
    avg_load = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      bb3_pkg::ST_IDLE:  mem_rd = start_push;
      bb3_pkg::ST_ISSUE: mem_rd = 1'b1;
      bb3_pkg::ST_RMW: begin
        mem_wr   = 1'b1;
        mem_addr = push_col_q;
      end
      bb3_pkg::ST_SUM:   avg_load = 1'b1;
      bb3_pkg::ST_OUT:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bb3_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // raster position of the next push, virtual pushes past the frame included
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_wr) begin
      row_q <= '0;
      col_q <= '0;
    end else if (state_q == bb3_pkg::ST_RMW) begin
      if (emit && last_d) begin
        row_q <= '0;
        col_q <= '0;
      end else if (wrap) begin
        row_q <= push_row_q + ROW_W'(1);
        col_q <= '0;
      end else begin
        row_q <= push_row_q;
        col_q <= COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      virt_q <= 1'b0;
    end else if (start_push || state_q == bb3_pkg::ST_ISSUE) begin
      virt_q <= frame_done;
    end
  end

  // latch the push, blank pixel past the frame
  always_ff @(posedge clk_i) begin
    if (start_push || state_q == bb3_pkg::ST_ISSUE) begin
      push_row_q <= row_q;
      push_col_q <= col_q;
      if (frame_done) begin
        pix_q <= '0;
      end else begin
        pix_q.red   <= in_i.data.red_in;
        pix_q.green <= in_i.data.green_in;
        pix_q.blue  <= in_i.data.blue_in;
      end
    end
  end

  // shift the window left, bring in the column just read
  always_ff @(posedge clk_i) begin
    if (state_q == bb3_pkg::ST_RMW) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= lb_upper;
      win_q[1][2] <= lb_middle;
      win_q[2][2] <= pix_q;
      clip_q      <= clip_d;
      last_q      <= last_d;
    end
  end

  bb3_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rd_en_i  (mem_rd),
    .wr_en_i  (mem_wr),
    .addr_i   (mem_addr),
    .pix_i    (pix_q),
    .upper_o  (lb_upper),
    .middle_o (lb_middle)
  );

  bb3_avg u_avg (
    .clk_i  (clk_i),
    .load_i (avg_load),
    .win_i  (win_q),
    .clip_i (clip_q),
    .avg_o  (avg_pix)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q  <= avg_pix;
      out_last_q <= last_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.data.red_out    = out_pix_q.red;
  assign out_o.data.green_out  = out_pix_q.green;
  assign out_o.data.blue_out   = out_pix_q.blue;
  assign out_o.data.frame_last = out_last_q;

endmodule
